@@ rtl/qbt_pkg.sv @@
package qbt_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int COL_W      = $clog2(MAX_SIZE);
    localparam int ROW_W      = $clog2(MAX_SIZE + 1);
    localparam int DIAG_W     = 2 * MAX_SIZE - 1;
    localparam int DIAG_IDX_W = $clog2(DIAG_W);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] col;
    } t_cand;

endpackage

@@ rtl/n_queens_backtrack_solver.sv @@
// Depth-first N-queens solver. Each transfer in gives the board size and the column of the
// row-zero queen; the block then places one queen per row, trying columns in ascending order
// and backtracking when a row has no free column. Each search step (place a queen or back up
// one row) is done by a single candidate unit that tests all columns of the current row
// against column and diagonal occupancy masks. An item passes through the transfer in, the
// search steps, a step that detects the full placement or the dead end, and its results;
// an output stall can hold it. Invalid requests (size zero, size above 16, first column off
// the board) skip the search. The input is not ready until the last result has been loaded
// into the output register. Results come one per row in row order, tlast on the final one;
// with no placement a single result with solved cleared is sent.
module n_queens_backtrack_solver
    import qbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [4:0] board_size, [8:5] first_column
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [0] solved, [4:1] row_index, [8:5] queen_column
    output logic                  o_m_axis_tlast   // last_result
);

    t_state                r_state, n_state;
    logic [ROW_W-1:0]      r_size, n_size;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [ROW_W-1:0]      r_start, n_start;
    logic [MAX_SIZE-1:0]   r_col_mask, n_col_mask;
    logic [DIAG_W-1:0]     r_d1_mask, n_d1_mask;
    logic [DIAG_W-1:0]     r_d2_mask, n_d2_mask;
    logic                  r_fail, n_fail;
    logic [COL_W-1:0]      r_cnt, n_cnt;
    logic                  r_o_valid, n_o_valid;
    logic                  r_o_solved, n_o_solved;
    logic [COL_W-1:0]      r_o_row, n_o_row;
    logic [COL_W-1:0]      r_o_col, n_o_col;
    logic                  r_o_last, n_o_last;

    logic [COL_W-1:0]      r_cpr [MAX_SIZE];

    logic                  w_accept;
    logic [ROW_W-1:0]      w_in_size;
    logic [COL_W-1:0]      w_in_col;
    logic                  w_bad;
    logic [COL_W-1:0]      w_prev_row;
    logic [COL_W-1:0]      w_rd_addr;
    logic [COL_W-1:0]      w_rd_q;
    logic                  w_we;
    logic [COL_W-1:0]      w_wr_addr;
    logic [COL_W-1:0]      w_wr_data;
    logic                  w_out_free;
    logic                  w_emit_last;
    t_cand                 w_cand;

    assign w_in_size  = i_s_axis_tdata[4:0];
    assign w_in_col   = i_s_axis_tdata[8:5];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_bad      = (w_in_size == '0) || (w_in_size > ROW_W'(MAX_SIZE))
                        || ({1'b0, w_in_col} >= w_in_size);
    assign w_prev_row = COL_W'(r_row - ROW_W'(1));
    assign w_rd_addr  = (r_state == S_EMIT) ? r_cnt : w_prev_row;
    assign w_rd_q     = r_cpr[w_rd_addr];
    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign w_emit_last = r_fail || ({1'b0, r_cnt} == r_size - ROW_W'(1));

    qbt_cand_unit u_cand (
        .i_row      (r_row[COL_W-1:0]),
        .i_start    (r_start),
        .i_size     (r_size),
        .i_col_mask (r_col_mask),
        .i_d1_mask  (r_d1_mask),
        .i_d2_mask  (r_d2_mask),
        .o_cand     (w_cand)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row      <= '0;
            r_start    <= '0;
            r_col_mask <= '0;
            r_d1_mask  <= '0;
            r_d2_mask  <= '0;
            r_fail     <= 1'b0;
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_start    <= n_start;
            r_col_mask <= n_col_mask;
            r_d1_mask  <= n_d1_mask;
            r_d2_mask  <= n_d2_mask;
            r_fail     <= n_fail;
            r_cnt      <= n_cnt;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_o_solved <= n_o_solved;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_last   <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cpr[w_wr_addr] <= w_wr_data;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_row      = r_row;
        n_start    = r_start;
        n_col_mask = r_col_mask;
        n_d1_mask  = r_d1_mask;
        n_d2_mask  = r_d2_mask;
        n_fail     = r_fail;
        n_cnt      = r_cnt;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_o_solved = r_o_solved;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_last   = r_o_last;
        w_we       = 1'b0;
        w_wr_addr  = '0;
        w_wr_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_size = w_in_size;
                    n_cnt  = '0;
                    if (w_bad) begin
                        n_fail  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_fail     = 1'b0;
                        n_row      = ROW_W'(1);
                        n_start    = '0;
                        n_col_mask = '0;
                        n_d1_mask  = '0;
                        n_d2_mask  = '0;
                        n_col_mask[w_in_col] = 1'b1;
                        n_d1_mask[DIAG_IDX_W'(w_in_col)] = 1'b1;
                        n_d2_mask[DIAG_IDX_W'(MAX_SIZE - 1) - DIAG_IDX_W'(w_in_col)] = 1'b1;
                        w_we      = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = w_in_col;
                        n_state   = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_row >= r_size) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else if (w_cand.found) begin
                    // place queen
                    w_we      = 1'b1;
                    w_wr_addr = r_row[COL_W-1:0];
                    w_wr_data = w_cand.col;
                    n_col_mask[w_cand.col] = 1'b1;
                    n_d1_mask[DIAG_IDX_W'(r_row[COL_W-1:0]) + DIAG_IDX_W'(w_cand.col)] = 1'b1;
                    n_d2_mask[DIAG_IDX_W'(r_row[COL_W-1:0]) + DIAG_IDX_W'(MAX_SIZE - 1)
                              - DIAG_IDX_W'(w_cand.col)] = 1'b1;
                    n_row   = r_row + ROW_W'(1);
                    n_start = '0;
                end else if (r_row == ROW_W'(1)) begin
                    n_fail  = 1'b1;
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    // back up: lift previous row's queen, resume one column right
                    n_col_mask[w_rd_q] = 1'b0;
                    n_d1_mask[DIAG_IDX_W'(w_prev_row) + DIAG_IDX_W'(w_rd_q)] = 1'b0;
                    n_d2_mask[DIAG_IDX_W'(w_prev_row) + DIAG_IDX_W'(MAX_SIZE - 1)
                              - DIAG_IDX_W'(w_rd_q)] = 1'b0;
                    n_row   = r_row - ROW_W'(1);
                    n_start = ROW_W'(w_rd_q) + ROW_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_solved = !r_fail;
                    n_o_row    = r_fail ? '0 : r_cnt;
                    n_o_col    = r_fail ? '0 : w_rd_q;
                    n_o_last   = w_emit_last;
                    n_cnt      = r_cnt + COL_W'(1);
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 1 - 2 * COL_W){1'b0}}, r_o_col, r_o_row, r_o_solved};
    assign o_m_axis_tlast  = r_o_last;

    // occupied columns track the depth of the search
    a_mask_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ($countones(r_col_mask) == 32'(r_row)))
        else $error("column mask out of step with search row");

    // search never backs up into the fixed row
    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_row != '0))
        else $error("search row reached zero");

    // an unsolved result is a lone zero result
    a_unsolved_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_solved) |-> (r_o_last && r_o_row == '0 && r_o_col == '0))
        else $error("malformed unsolved result");

    // a new search only starts from idle with the input handshake
    a_search_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !w_accept) |=> (r_state == S_IDLE))
        else $error("left idle without a transfer");

endmodule

@@ rtl/qbt_cand_unit.sv @@
module qbt_cand_unit
    import qbt_pkg::*;
(
    input  logic [COL_W-1:0]    i_row,
    input  logic [ROW_W-1:0]    i_start,
    input  logic [ROW_W-1:0]    i_size,
    input  logic [MAX_SIZE-1:0] i_col_mask,
    input  logic [DIAG_W-1:0]   i_d1_mask,
    input  logic [DIAG_W-1:0]   i_d2_mask,
    output t_cand               o_cand
);

    logic [DIAG_IDX_W-1:0] w_idx1 [MAX_SIZE];
    logic [DIAG_IDX_W-1:0] w_idx2 [MAX_SIZE];
    logic [MAX_SIZE-1:0]   w_avail;

    // per-column attack test: column, rising and falling diagonals, window [start, size)
    always_comb begin
        for (int c = 0; c < MAX_SIZE; c++) begin
            w_idx1[c] = DIAG_IDX_W'(i_row) + DIAG_IDX_W'(c);
            w_idx2[c] = DIAG_IDX_W'(i_row) + DIAG_IDX_W'(MAX_SIZE - 1 - c);
            w_avail[c] = (ROW_W'(c) >= i_start) && (ROW_W'(c) < i_size)
                         && !i_col_mask[c] && !i_d1_mask[w_idx1[c]]
                         && !i_d2_mask[w_idx2[c]];
        end
    end

    // lowest free column
    always_comb begin
        o_cand.found = 1'b0;
        o_cand.col   = '0;
        for (int c = MAX_SIZE - 1; c >= 0; c--) begin
            if (w_avail[c]) begin
                o_cand.found = 1'b1;
                o_cand.col   = COL_W'(c);
            end
        end
    end

endmodule
